FILE: rtl/core/serial_attribute_row_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// Serial attribute row decoder assertion macros
// Shared concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SERIAL_ATTRIBUTE_ROW_DECODER_CORE_MACROS_SVH
`define SERIAL_ATTRIBUTE_ROW_DECODER_CORE_MACROS_SVH
`ifndef SYNTH
`define SARD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("sard: assertion failed");
`define SARD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sard: assertion failed");
`else
`define SARD_ASSERT(lbl, prop)
`define SARD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/sard_pkg.sv
// ----------------------------------------------------------------------------
// sard_pkg
// Types, control codes and glyph mapping for the serial attribute row decoder.
// ----------------------------------------------------------------------------
package sard_pkg;

    localparam int C_COLS = 40;

    localparam logic [7:0] C_CODE_BG_FG      = 8'h1D;
    localparam logic [7:0] C_CODE_BG_BLACK   = 8'h1C;
    localparam logic [7:0] C_CODE_BLINK_ON   = 8'h08;
    localparam logic [7:0] C_CODE_BLINK_OFF  = 8'h09;
    localparam logic [7:0] C_CODE_NORMAL_H   = 8'h0C;
    localparam logic [7:0] C_CODE_DOUBLE_H   = 8'h0D;
    localparam logic [7:0] C_CODE_FIRST_SHOW = 8'h20;
    localparam logic [7:0] C_CODE_HIGH       = 8'h80;
    localparam logic [7:0] C_MOSAIC_LOW_BASE = 8'h60;
    localparam logic [7:0] C_MOSAIC_HI_BASE  = 8'h80;
    localparam logic [7:0] C_MOSAIC_HI_START = 8'h40;
    localparam logic [7:0] C_MOSAIC_LETTERS  = 8'h20;

    localparam logic [2:0] C_FG_DEFAULT = 3'd7;
    localparam logic [2:0] C_BG_DEFAULT = 3'd0;

    localparam logic [1:0] C_HEIGHT_NORMAL = 2'd0;
    localparam logic [1:0] C_HEIGHT_UPPER  = 2'd1;
    localparam logic [1:0] C_HEIGHT_LOWER  = 2'd2;
    localparam logic [1:0] C_HEIGHT_BAD    = 2'd3;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] prev_code;
        logic       lower;
        logic       row_start;
    } t_cell;

    function automatic logic [7:0] glyph_of(input logic [7:0] c, input logic mosaic);
        logic [7:0] d;
        logic [7:0] g;
        d = c - C_CODE_FIRST_SHOW;
        if (c < C_CODE_FIRST_SHOW || c >= C_CODE_HIGH) begin
            g = 8'd0;
        end else if (!mosaic) begin
            g = d;
        end else if (d < C_MOSAIC_LETTERS) begin
            g = C_MOSAIC_LOW_BASE + d;
        end else if (d < C_MOSAIC_HI_START) begin
            g = d;
        end else begin
            g = C_MOSAIC_HI_BASE + (d - C_MOSAIC_HI_START);
        end
        return g;
    endfunction

endpackage

FILE: rtl/core/sard_input.sv
// ----------------------------------------------------------------------------
// sard_input
// Column and row tracking, line store and input register of the decoder.
// ----------------------------------------------------------------------------
`include "serial_attribute_row_decoder_core_macros.svh"

module sard_input
    import sard_pkg::*;
#(
    parameter int COLS = C_COLS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_code,
    input  logic       i_frame_start,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cell      o_cell
);

    localparam int CW = $clog2(COLS);

    logic [7:0]    r_mem [COLS];
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic          r_lh;
    logic          r_rhd;
    logic          n_rhd;
    logic          r_valid;
    logic [7:0]    r_code;
    logic [7:0]    r_prev;
    logic          r_lower;
    logic          r_row_start;
    logic          w_accept;
    logic [CW-1:0] w_cell_col;
    logic          w_row_start;
    logic          w_lower;

    assign o_ready     = !r_valid || i_ready;
    assign w_accept    = i_valid && o_ready;
    assign w_cell_col  = i_frame_start ? '0 : r_col;
    assign w_row_start = i_frame_start || (r_col == '0);
    assign w_lower     = i_frame_start ? 1'b0 : ((r_col == '0) ? r_rhd : r_lh);
    assign n_col       = (w_cell_col == CW'(COLS - 1)) ? '0 : w_cell_col + 1'b1;
    assign n_rhd       = (w_row_start ? 1'b0 : r_rhd) || (i_code == C_CODE_DOUBLE_H);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_lh    <= 1'b0;
            r_rhd   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_col <= n_col;
                r_lh  <= w_lower;
                r_rhd <= n_rhd;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prev             <= r_mem[w_cell_col];
            r_mem[w_cell_col]  <= i_code;
            r_code             <= i_code;
            r_lower            <= w_lower;
            r_row_start        <= w_row_start;
        end
    end

    assign o_valid          = r_valid;
    assign o_cell.code      = r_code;
    assign o_cell.prev_code = r_prev;
    assign o_cell.lower     = r_lower;
    assign o_cell.row_start = r_row_start;

    `SARD_ASSERT(a_col_range, r_col <= CW'(COLS - 1))
    `SARD_ASSERT_NEXT(a_fs_restart, w_accept && i_frame_start, r_col == CW'(1) && !r_lh)
    `SARD_ASSERT_NEXT(a_hold_stalled, r_valid && !i_ready, r_valid && $stable(r_code))

endmodule

FILE: rtl/core/sard_attr.sv
// ----------------------------------------------------------------------------
// sard_attr
// Running serial attributes, glyph mapping and result register.
// ----------------------------------------------------------------------------
`include "serial_attribute_row_decoder_core_macros.svh"

module sard_attr
    import sard_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cell      i_cell,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_glyph,
    output logic [2:0] o_fg,
    output logic [2:0] o_bg,
    output logic       o_blink,
    output logic [1:0] o_height
);

    logic [2:0] r_fg_col;
    logic [2:0] r_bg_col;
    logic       r_mosaic;
    logic       r_blink_on;
    logic       r_dh;
    logic [2:0] n_fg;
    logic [2:0] n_bg;
    logic       n_mosaic;
    logic       n_blink;
    logic       n_dh;
    logic [7:0] n_glyph;
    logic [1:0] n_height;
    logic [7:0] w_c;
    logic       w_set_fg;
    logic       w_adv;
    logic       r_out_valid;
    logic [7:0] r_glyph;
    logic [2:0] r_out_fg;
    logic [2:0] r_out_bg;
    logic       r_out_blink;
    logic [1:0] r_height;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_adv    = i_valid && o_ready;
    assign w_c      = i_cell.lower ? i_cell.prev_code : i_cell.code;
    assign w_set_fg = (w_c[7:5] == 3'b000) && !w_c[3];

    always_comb begin
        n_fg     = i_cell.row_start ? C_FG_DEFAULT : r_fg_col;
        n_bg     = i_cell.row_start ? C_BG_DEFAULT : r_bg_col;
        n_mosaic = i_cell.row_start ? 1'b0 : r_mosaic;
        n_blink  = i_cell.row_start ? 1'b0 : r_blink_on;
        n_dh     = i_cell.row_start ? 1'b0 : r_dh;
        if (w_set_fg) begin
            n_fg     = w_c[2:0];
            n_mosaic = w_c[4];
        end
        if (w_c == C_CODE_BG_FG) begin
            n_bg = n_fg;
        end
        if (w_c == C_CODE_BG_BLACK) begin
            n_bg = C_BG_DEFAULT;
        end
        if (w_c == C_CODE_BLINK_ON) begin
            n_blink = 1'b1;
        end
        if (w_c == C_CODE_BLINK_OFF) begin
            n_blink = 1'b0;
        end
        if (w_c == C_CODE_NORMAL_H) begin
            n_dh = 1'b0;
        end
        if (w_c == C_CODE_DOUBLE_H) begin
            n_dh = 1'b1;
        end
        priority if (i_cell.lower && !n_dh) begin
            n_glyph  = 8'd0;
            n_height = C_HEIGHT_NORMAL;
        end else if (i_cell.lower) begin
            n_glyph  = glyph_of(w_c, n_mosaic);
            n_height = C_HEIGHT_LOWER;
        end else begin
            n_glyph  = glyph_of(w_c, n_mosaic);
            n_height = n_dh ? C_HEIGHT_UPPER : C_HEIGHT_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_col    <= C_FG_DEFAULT;
            r_bg_col    <= C_BG_DEFAULT;
            r_mosaic    <= 1'b0;
            r_blink_on  <= 1'b0;
            r_dh        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_fg_col   <= n_fg;
                r_bg_col   <= n_bg;
                r_mosaic   <= n_mosaic;
                r_blink_on <= n_blink;
                r_dh       <= n_dh;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_glyph     <= n_glyph;
            r_out_fg    <= n_fg;
            r_out_bg    <= n_bg;
            r_out_blink <= n_blink;
            r_height    <= n_height;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_glyph  = r_glyph;
    assign o_fg     = r_out_fg;
    assign o_bg     = r_out_bg;
    assign o_blink  = r_out_blink;
    assign o_height = r_height;

    `SARD_ASSERT(a_height_code, !r_out_valid || (r_height != C_HEIGHT_BAD))
    `SARD_ASSERT_NEXT(a_blank_cell, w_adv && i_cell.lower && !n_dh, r_glyph == 8'd0 && r_height == C_HEIGHT_NORMAL)
    `SARD_ASSERT_NEXT(a_row_start_fg, w_adv && i_cell.row_start && !w_set_fg, r_out_fg == C_FG_DEFAULT)

endmodule

FILE: rtl/core/serial_attribute_row_decoder_core.sv
// The result of an accepted transaction passes the input register, then the result register.
// Throughput: one cell per cycle unless stalled; one line store read and one write per cell.
// A master-side stall holds the result register; the input register takes at most one
// more cell, then tready drops until the master side accepts again.
// Reset (i_rst_n low, synchronous) clears column, row tracking, attributes and valids.
// The line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// serial_attribute_row_decoder_core
// Serial attribute row decoder: raw character codes in, glyph and attributes out.
// ----------------------------------------------------------------------------
module serial_attribute_row_decoder_core
    import sard_pkg::*;
#(
    parameter int COLS = C_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // code[7:0]
    input  logic        i_s_axis_tuser,   // frame_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // glyph[7:0], foreground[10:8], background[13:11],
                                          // blink[14], height[16:15], zero[23:17]
);

    t_cell      w_cell;
    logic       w_cell_valid;
    logic       w_cell_ready;
    logic [7:0] w_glyph;
    logic [2:0] w_fg;
    logic [2:0] w_bg;
    logic       w_blink;
    logic [1:0] w_height;

    sard_input #(
        .COLS (COLS)
    ) u_input (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_code        (i_s_axis_tdata),
        .i_frame_start (i_s_axis_tuser),
        .o_valid       (w_cell_valid),
        .i_ready       (w_cell_ready),
        .o_cell        (w_cell)
    );

    sard_attr u_attr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_cell_valid),
        .o_ready  (w_cell_ready),
        .i_cell   (w_cell),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_glyph  (w_glyph),
        .o_fg     (w_fg),
        .o_bg     (w_bg),
        .o_blink  (w_blink),
        .o_height (w_height)
    );

    assign o_m_axis_tdata = {7'd0, w_height, w_blink, w_bg, w_fg, w_glyph};

endmodule

FILE: verif/tb_serial_attribute_row_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_serial_attribute_row_decoder_core
// Self-checking bench for the serial attribute row decoder. A directed table
// walks the control codes, glyph ranges and a mid-row frame restart, then
// random frames of rows (most with double height, so lower halves follow)
// run with random idle bursts on both stream sides in parts of the run. Each
// output is checked field by field against the table or an in-bench cell decoder.
// ----------------------------------------------------------------------------
module tb_serial_attribute_row_decoder_core;
    import sard_pkg::*;

    localparam int         ROW_CELLS    = C_COLS;
    localparam logic [7:0] TEXT_BLACK   = 8'h00;
    localparam logic [7:0] TEXT_RED     = 8'h01;
    localparam logic [7:0] TEXT_WHITE   = 8'h07;
    localparam logic [7:0] MOSAIC_BLACK = 8'h10;
    localparam logic [7:0] MOSAIC_GREEN = 8'h12;
    localparam logic [7:0] MOSAIC_WHITE = 8'h17;

    typedef struct packed {
        logic [7:0] glyph;
        logic [2:0] fg;
        logic [2:0] bg;
        logic       blink;
        logic [1:0] height;
    } t_exp_cell;

    typedef struct {
        logic [7:0] code;
        logic       fs;
        bit         typed;
        t_exp_cell  want;
    } t_stim_row;

    logic        i_clk    = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b1;
    logic        s_typed  = 1'b0;
    t_exp_cell   s_want   = '0;
    logic        idle_en  = 1'b1;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;

    // decoder state
    int          col;
    logic [7:0]  line_store [0:63];
    logic        lower_half;
    logic        row_dh;
    logic [2:0]  fg_now;
    logic [2:0]  bg_now;
    logic        mosaic;
    logic        blink_now;
    logic        dh_now;

    t_exp_cell   exp_cells [$];
    int          n_mismatch;
    int          n_sent;
    int          stall_left = 0;
    t_stim_row   directed_rows [25];

    serial_attribute_row_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_exp_cell decode_cell(input logic [7:0] raw, input logic fs);
        logic [7:0] c;
        t_exp_cell  r;
        if (fs || col == 0) begin
            if (fs) begin
                col        = 0;
                lower_half = 1'b0;
            end else begin
                lower_half = row_dh;
            end
            row_dh    = 1'b0;
            fg_now    = C_FG_DEFAULT;
            bg_now    = C_BG_DEFAULT;
            mosaic    = 1'b0;
            blink_now = 1'b0;
            dh_now    = 1'b0;
        end
        c = lower_half ? line_store[col] : raw;
        line_store[col] = raw;
        if (raw == C_CODE_DOUBLE_H) begin
            row_dh = 1'b1;
        end
        if (c[7:3] == 5'b00000 || c[7:3] == 5'b00010) begin
            fg_now = c[2:0];
            mosaic = c[4];
        end
        case (c)
            C_CODE_BG_FG:     bg_now    = fg_now;
            C_CODE_BG_BLACK:  bg_now    = C_BG_DEFAULT;
            C_CODE_BLINK_ON:  blink_now = 1'b1;
            C_CODE_BLINK_OFF: blink_now = 1'b0;
            C_CODE_NORMAL_H:  dh_now    = 1'b0;
            C_CODE_DOUBLE_H:  dh_now    = 1'b1;
            default: ;
        endcase
        r.fg    = fg_now;
        r.bg    = bg_now;
        r.blink = blink_now;
        if (lower_half && !dh_now) begin
            r.glyph  = 8'd0;
            r.height = C_HEIGHT_NORMAL;
        end else begin
            if (c < C_CODE_FIRST_SHOW || c[7]) begin
                r.glyph = 8'd0;
            end else if (!mosaic || c[6:5] == 2'b10) begin
                r.glyph = c - C_CODE_FIRST_SHOW;
            end else if (c[6:5] == 2'b01) begin
                r.glyph = c + 8'h40;
            end else begin
                r.glyph = c + 8'h20;
            end
            r.height = lower_half ? C_HEIGHT_LOWER : (dh_now ? C_HEIGHT_UPPER : C_HEIGHT_NORMAL);
        end
        col = (col + 1 >= ROW_CELLS) ? 0 : col + 1;
        return r;
    endfunction

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return 8'($urandom_range(0, 31));
        end else if (r < 80) begin
            return 8'($urandom_range(32, 127));
        end
        return 8'($urandom_range(128, 255));
    endfunction

    always @(posedge i_clk) begin
        t_exp_cell pred;
        t_exp_cell got;
        t_exp_cell want;
        if (rst_n && s_tvalid && o_s_axis_tready) begin
            pred = decode_cell(s_tdata, s_tuser);
            exp_cells.push_back(s_typed ? s_want : pred);
        end
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            got.glyph  = o_m_axis_tdata[7:0];
            got.fg     = o_m_axis_tdata[10:8];
            got.bg     = o_m_axis_tdata[13:11];
            got.blink  = o_m_axis_tdata[14];
            got.height = o_m_axis_tdata[16:15];
            if (exp_cells.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("unexpected output transaction: tdata %h", o_m_axis_tdata);
                end
            end else begin
                want = exp_cells.pop_front();
                if (got.glyph !== want.glyph || got.fg !== want.fg || got.bg !== want.bg ||
                    got.blink !== want.blink || got.height !== want.height ||
                    o_m_axis_tdata[23:17] !== 7'd0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display({"mismatch (exp/act): glyph %h/%h fg %0d/%0d bg %0d/%0d",
                                  " blink %0d/%0d height %0d/%0d pad %h"},
                                 want.glyph, got.glyph, want.fg, got.fg, want.bg, got.bg,
                                 want.blink, got.blink, want.height, got.height,
                                 o_m_axis_tdata[23:17]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!idle_en) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end else begin
            m_tready   <= 1'b1;
        end
    end

    task automatic send_cell(input logic [7:0] code, input logic fs, input bit typed,
                             input t_exp_cell want);
        bit gaps_on;
        gaps_on = (n_sent < 300) || (n_sent >= 420 && n_sent < 680);
        idle_en <= gaps_on;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= fs;
        s_typed  <= typed;
        s_want   <= want;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (exp_cells.size() != 0);
    endtask

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int         rows;
        int         cut;
        int         dh_col;
        bit         paused;
        logic [7:0] code;
        col        = 0;
        lower_half = 1'b0;
        row_dh     = 1'b0;
        fg_now     = C_FG_DEFAULT;
        bg_now     = C_BG_DEFAULT;
        mosaic     = 1'b0;
        blink_now  = 1'b0;
        dh_now     = 1'b0;
        n_mismatch = 0;
        n_sent     = 0;
        paused     = 1'b0;
        directed_rows = '{
            '{8'h41,            1'b1, 1'b1, '{8'h21, 3'd7, 3'd0, 1'b0, C_HEIGHT_NORMAL}},
            '{TEXT_BLACK,       1'b0, 1'b1, '{8'h00, 3'd0, 3'd0, 1'b0, C_HEIGHT_NORMAL}},
            '{TEXT_RED,         1'b0, 1'b1, '{8'h00, 3'd1, 3'd0, 1'b0, C_HEIGHT_NORMAL}},
            '{C_CODE_BG_FG,     1'b0, 1'b1, '{8'h00, 3'd1, 3'd1, 1'b0, C_HEIGHT_NORMAL}},
            '{8'h20,            1'b0, 1'b1, '{8'h00, 3'd1, 3'd1, 1'b0, C_HEIGHT_NORMAL}},
            '{8'h7f,            1'b0, 1'b1, '{8'h5f, 3'd1, 3'd1, 1'b0, C_HEIGHT_NORMAL}},
            '{8'h80,            1'b0, 1'b1, '{8'h00, 3'd1, 3'd1, 1'b0, C_HEIGHT_NORMAL}},
            '{8'hff,            1'b0, 1'b1, '{8'h00, 3'd1, 3'd1, 1'b0, C_HEIGHT_NORMAL}},
            '{C_CODE_BG_BLACK,  1'b0, 1'b1, '{8'h00, 3'd1, 3'd0, 1'b0, C_HEIGHT_NORMAL}},
            '{C_CODE_BLINK_ON,  1'b0, 1'b1, '{8'h00, 3'd1, 3'd0, 1'b1, C_HEIGHT_NORMAL}},
            '{C_CODE_BLINK_OFF, 1'b0, 1'b1, '{8'h00, 3'd1, 3'd0, 1'b0, C_HEIGHT_NORMAL}},
            '{C_CODE_DOUBLE_H,  1'b0, 1'b1, '{8'h00, 3'd1, 3'd0, 1'b0, C_HEIGHT_UPPER}},
            '{MOSAIC_GREEN,     1'b0, 1'b0, '0},
            '{8'h20,            1'b0, 1'b0, '0},
            '{8'h3f,            1'b0, 1'b0, '0},
            '{8'h40,            1'b0, 1'b0, '0},
            '{8'h5f,            1'b0, 1'b0, '0},
            '{8'h60,            1'b0, 1'b0, '0},
            '{8'h7f,            1'b0, 1'b0, '0},
            '{C_CODE_NORMAL_H,  1'b0, 1'b0, '0},
            '{MOSAIC_WHITE,     1'b0, 1'b0, '0},
            '{TEXT_WHITE,       1'b0, 1'b0, '0},
            '{MOSAIC_BLACK,     1'b0, 1'b0, '0},
            '{C_CODE_DOUBLE_H,  1'b1, 1'b1, '{8'h00, 3'd7, 3'd0, 1'b0, C_HEIGHT_UPPER}},
            '{8'h41,            1'b0, 1'b1, '{8'h21, 3'd7, 3'd0, 1'b0, C_HEIGHT_UPPER}}
        };
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_cell(directed_rows[i].code, directed_rows[i].fs, directed_rows[i].typed,
                      directed_rows[i].want);
        end
        wait_drained();

        // whole rows, most carrying double height; a few frames cut mid-row
        while (n_sent < 740) begin
            rows = $urandom_range(1, 5);
            for (int r = 0; r < rows; r++) begin
                cut    = (r == rows - 1 && $urandom_range(0, 9) == 0) ?
                         $urandom_range(1, ROW_CELLS - 1) : ROW_CELLS;
                dh_col = ($urandom_range(0, 2) != 0) ? $urandom_range(0, ROW_CELLS - 1) : -1;
                for (int c = 0; c < cut; c++) begin
                    code = (c == dh_col) ? C_CODE_DOUBLE_H : pick_code();
                    send_cell(code, (r == 0 && c == 0), 1'b0, '0);
                end
            end
            if (!paused && n_sent >= 500) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
